// File: design/graph_diameter_connectivity_macros.svh
`ifndef GRAPH_DIAMETER_CONNECTIVITY_MACROS_SVH
`define GRAPH_DIAMETER_CONNECTIVITY_MACROS_SVH

// same-cycle implication
`define GDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/gdc_pkg.sv
`default_nettype none

package gdc_pkg;

   localparam int MAX_VERTICES_DEFAULT = 32;

   localparam int IDX_W  = 5;
   localparam int ROW_W  = 32;
   localparam int VC_W   = 6;
   localparam int DIAM_W = 5;

   localparam logic [VC_W-1:0]   VC_RESET  = 6'd32;
   localparam logic [DIAM_W-1:0] LEVEL_MAX = 5'd31;

   typedef struct packed {
      logic              connected;
      logic              has_isolated;
      logic [DIAM_W-1:0] diameter;
   } result_type;

endpackage

`default_nettype wire

// File: design/gdc_if.sv
`default_nettype none

interface gdc_req_if;
   logic                       valid;
   logic                       ready;
   logic [gdc_pkg::IDX_W-1:0]  vertex_index;
   logic [gdc_pkg::ROW_W-1:0]  adjacency_row;
   logic                       last_row;

   modport source (output valid, output vertex_index, output adjacency_row,
                   output last_row, input ready);
   modport sink   (input valid, input vertex_index, input adjacency_row,
                   input last_row, output ready);
endinterface

interface gdc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       connected;
   logic                       has_isolated;
   logic [gdc_pkg::DIAM_W-1:0] diameter;

   modport source (output valid, output connected, output has_isolated,
                   output diameter, input ready);
   modport sink   (input valid, input connected, input has_isolated,
                   input diameter, output ready);
endinterface

`default_nettype wire

// File: design/gdc_cell.sv
`default_nettype none

module gdc_cell #(
   parameter int MAX_VERTICES = gdc_pkg::MAX_VERTICES_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [MAX_VERTICES-1:0] wr_row,
   input  wire logic                    frontier_bit,
   input  wire logic [MAX_VERTICES-1:0] mask,
   input  wire logic [MAX_VERTICES-1:0] acc_prev,
   output logic      [MAX_VERTICES-1:0] acc_out,
   output logic                         iso
);

   logic [MAX_VERTICES-1:0] row_ff, row_in;
   logic [MAX_VERTICES-1:0] acc_ff, acc_in;

   always_comb begin
      row_in = wr_en ? wr_row : row_ff;
      acc_in = acc_prev | (frontier_bit ? row_ff : '0);
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      acc_ff <= acc_in;
   end

   assign acc_out = acc_ff;
   assign iso     = ~|(row_ff & mask);

endmodule

`default_nettype wire

// File: design/gdc_seq.sv
`default_nettype none

module gdc_seq #(
   parameter int MAX_VERTICES = gdc_pkg::MAX_VERTICES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         out_free,
   input  wire logic [gdc_pkg::VC_W-1:0]     vertex_count,
   input  wire logic [MAX_VERTICES-1:0]      acc_last,
   input  wire logic [MAX_VERTICES-1:0]      iso_vec,
   output logic      [MAX_VERTICES-1:0]      frontier,
   output logic      [MAX_VERTICES-1:0]      mask,
   output logic                              idle,
   output logic                              done,
   output gdc_pkg::result_type               result
);

   localparam int VW = $clog2(MAX_VERTICES + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WAVE   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [VW-1:0]                   src_ff, src_in;
   logic [VW-1:0]                   cnt_ff, cnt_in;
   logic [MAX_VERTICES-1:0]         visited_ff, visited_in;
   logic [MAX_VERTICES-1:0]         frontier_ff, frontier_in;
   logic [gdc_pkg::DIAM_W-1:0]      level_ff, level_in;
   logic [gdc_pkg::DIAM_W-1:0]      maxecc_ff, maxecc_in;
   logic                            conn_ff, conn_in;

   logic [VW-1:0]                   v_use;
   logic [VW-1:0]                   src_nxt;
   logic [MAX_VERTICES-1:0]         onehot_nxt;
   logic [MAX_VERTICES-1:0]         reach;
   logic                            wave_end;
   logic                            src_last;
   logic                            src_ok;

   always_comb begin
      if (vertex_count == '0) begin
         v_use = VW'(1);
      end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
         v_use = VW'(MAX_VERTICES);
      end else begin
         v_use = VW'(vertex_count);
      end
   end

   always_comb begin
      src_nxt = src_ff + VW'(1);
      for (int j = 0; j < MAX_VERTICES; j++) begin
         mask[j]       = (32'(j) < 32'(v_use));
         onehot_nxt[j] = (src_nxt == VW'(j));
      end
   end

   assign reach    = acc_last & mask & ~visited_ff;
   assign wave_end = (cnt_ff == VW'(MAX_VERTICES));
   assign src_last = (src_ff == v_use - VW'(1));
   assign src_ok   = (visited_ff == mask);

   always_comb begin
      state_in    = state_ff;
      src_in      = src_ff;
      cnt_in      = cnt_ff;
      visited_in  = visited_ff;
      frontier_in = frontier_ff;
      level_in    = level_ff;
      maxecc_in   = maxecc_ff;
      conn_in     = conn_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               src_in      = '0;
               visited_in  = MAX_VERTICES'(1);
               frontier_in = MAX_VERTICES'(1);
               level_in    = '0;
               maxecc_in   = '0;
               conn_in     = 1'b1;
               cnt_in      = '0;
               state_in    = S_WAVE;
            end
         end
         S_WAVE: begin
            if (!wave_end) begin
               cnt_in = cnt_ff + VW'(1);
            end else if (reach != '0) begin
               level_in    = (level_ff == gdc_pkg::LEVEL_MAX) ? level_ff
                                                             : level_ff + gdc_pkg::DIAM_W'(1);
               visited_in  = visited_ff | reach;
               frontier_in = reach;
               cnt_in      = '0;
            end else begin
               if (!src_ok) begin
                  conn_in = 1'b0;
               end else if (level_ff > maxecc_ff) begin
                  maxecc_in = level_ff;
               end
               if (src_last) begin
                  frontier_in = '0;
                  state_in    = S_FINISH;
               end else begin
                  src_in      = src_nxt;
                  visited_in  = onehot_nxt;
                  frontier_in = onehot_nxt;
                  level_in    = '0;
                  cnt_in      = '0;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               src_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         src_ff      <= '0;
         cnt_ff      <= '0;
         visited_ff  <= '0;
         frontier_ff <= '0;
         level_ff    <= '0;
         maxecc_ff   <= '0;
         conn_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         src_ff      <= src_in;
         cnt_ff      <= cnt_in;
         visited_ff  <= visited_in;
         frontier_ff <= frontier_in;
         level_ff    <= level_in;
         maxecc_ff   <= maxecc_in;
         conn_ff     <= conn_in;
      end
   end

   assign frontier            = frontier_ff;
   assign idle                = (state_ff == S_IDLE);
   assign done                = (state_ff == S_FINISH) && out_free;
   assign result.connected    = conn_ff;
   assign result.has_isolated = |(iso_vec & mask);
   assign result.diameter     = conn_ff ? maxecc_ff : '0;

endmodule

`default_nettype wire

// File: design/graph_diameter_connectivity.sv
// channel   dir  handshake      payload
// req_chan  in   valid/ready    vertex_index, adjacency_row, last_row
// rsp_chan  out  valid/ready    connected, has_isolated, diameter
// csr       in   csr_wr_en      csr_wr_data (vertex count)
//
// A row item with last_row clear is stored in the row register of the cell that vertex_index names.
// A last_row item starts a search from every used vertex; each search level is
// one wave down the row of cells, and the result is ready once every search ends.
// Reset is synchronous, active high; stored rows are undefined until written.
// req_chan.ready stays low while a search runs; the result register lets a new
// item in while rsp_chan is stalled.
`default_nettype none

module graph_diameter_connectivity #(
   parameter int MAX_VERTICES = gdc_pkg::MAX_VERTICES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   gdc_req_if.sink                       req_chan,
   gdc_rsp_if.source                     rsp_chan,
   input  wire logic                     csr_wr_en,
   input  wire logic [gdc_pkg::VC_W-1:0] csr_wr_data
);

   logic [gdc_pkg::VC_W-1:0] csr_vc_ff, csr_vc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   gdc_pkg::result_type      rsp_data_ff, rsp_data_in;

   logic                     req_accept;
   logic                     out_free;
   logic                     seq_idle;
   logic                     seq_done;
   gdc_pkg::result_type      seq_result;
   logic [MAX_VERTICES-1:0]  frontier;
   logic [MAX_VERTICES-1:0]  mask;
   logic [MAX_VERTICES-1:0]  iso_vec;
   logic [MAX_VERTICES-1:0]  wr_sel;
   logic [MAX_VERTICES-1:0]  row_ext;
   logic [MAX_VERTICES-1:0]  acc_chain [MAX_VERTICES+1];

   assign req_chan.ready = seq_idle;
   assign req_accept     = req_chan.valid && seq_idle;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign row_ext        = MAX_VERTICES'(req_chan.adjacency_row);
   assign acc_chain[0]   = '0;

   always_comb begin
      csr_vc_in    = csr_wr_en ? csr_wr_data : csr_vc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_vc_ff    <= gdc_pkg::VC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_vc_ff    <= csr_vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.connected    = rsp_data_ff.connected;
   assign rsp_chan.has_isolated = rsp_data_ff.has_isolated;
   assign rsp_chan.diameter     = rsp_data_ff.diameter;

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      assign wr_sel[i] = req_accept && (32'(req_chan.vertex_index) == 32'(i));

      gdc_cell #(.MAX_VERTICES(MAX_VERTICES)) u_cell (
         .clock        (clock),
         .wr_en        (wr_sel[i]),
         .wr_row       (row_ext),
         .frontier_bit (frontier[i]),
         .mask         (mask),
         .acc_prev     (acc_chain[i]),
         .acc_out      (acc_chain[i+1]),
         .iso          (iso_vec[i])
      );
   end

   gdc_seq #(.MAX_VERTICES(MAX_VERTICES)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (req_accept && req_chan.last_row),
      .out_free     (out_free),
      .vertex_count (csr_vc_ff),
      .acc_last     (acc_chain[MAX_VERTICES]),
      .iso_vec      (iso_vec),
      .frontier     (frontier),
      .mask         (mask),
      .idle         (seq_idle),
      .done         (seq_done),
      .result       (seq_result)
   );

endmodule

`default_nettype wire

// File: design/gdc_checker.sv
`default_nettype none
`include "graph_diameter_connectivity_macros.svh"

module gdc_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_last,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_connected,
   input wire logic                       rsp_has_isolated,
   input wire logic [gdc_pkg::DIAM_W-1:0] rsp_diameter
);

   `GDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_connected) && $stable(rsp_has_isolated) && $stable(rsp_diameter), "rsp item changed while stalled")
   `GDC_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_last, !req_ready, "req ready after last row")
   `GDC_ASSERT_NEXT(a_row_keeps_ready, clock, reset, req_valid && req_ready && !req_last, req_ready, "req ready dropped on plain row")
   `GDC_ASSERT_NOW(a_diam_unconnected, clock, reset, rsp_valid && !rsp_connected, rsp_diameter == '0, "diameter nonzero on unconnected graph")

endmodule

bind graph_diameter_connectivity gdc_checker u_gdc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_last         (req_chan.last_row),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_connected    (rsp_chan.connected),
   .rsp_has_isolated (rsp_chan.has_isolated),
   .rsp_diameter     (rsp_chan.diameter)
);

`default_nettype wire
